[rtl/core/rps_pkg.sv]
// ----------------------------------------------------------------------------
// rps_pkg
// shared types and constants for the roulette population select block
// ----------------------------------------------------------------------------
package rps_pkg;

	localparam int POP_SIZE_DEF = 32;
	localparam int FIT_W        = 32;
	localparam int ID_W         = 16;
	localparam int FRAC_W       = 32;
	localparam int RECIP_W      = 32;
	localparam int REQ_W        = 2;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;

	// request codes
	localparam logic [REQ_W-1:0] REQ_OFFER  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SELECT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FITNESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ENABLE  = 1'd1;

	// one table entry
	typedef struct packed {
		logic [FIT_W-1:0]   fit;
		logic [ID_W-1:0]    id;
		logic [RECIP_W-1:0] recip;
	} entry_t;

	// what every cell does in a cycle
	typedef enum logic [1:0] {
		CM_HOLD    = 2'd0,
		CM_INSERT  = 2'd1,
		CM_REPLACE = 2'd2,
		CM_ROTATE  = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		entry_t     new_ent;
	} cell_ctrl_t;

endpackage

[rtl/core/rps_cell.sv]
// ----------------------------------------------------------------------------
// rps_cell
// one slot of the ordered population chain
// ----------------------------------------------------------------------------
module rps_cell #(
	parameter int POP_SIZE = rps_pkg::POP_SIZE_DEF,
	parameter int IDX      = 0
) (
	input  logic                          clk,
	input  rps_pkg::cell_ctrl_t           ctrl,
	input  logic [$clog2(POP_SIZE+1)-1:0] cnt,
	input  rps_pkg::entry_t               left_ent,
	input  logic                          left_gt,
	input  rps_pkg::entry_t               right_ent,
	input  logic                          right_gt,
	output rps_pkg::entry_t               ent,
	output logic                          gt
);

	localparam int CW = $clog2(POP_SIZE+1);

	rps_pkg::entry_t ent_q;

	// slot is occupied and no better than the offered fitness
	assign gt  = (CW'(IDX) < cnt) && (ent_q.fit >= ctrl.new_ent.fit);
	assign ent = ent_q;

	// shift, insert or rotate
	always_ff @(posedge clk) begin
		case (ctrl.mode)
			rps_pkg::CM_INSERT: begin
				if (!gt) begin
					if (left_gt) ent_q <= ctrl.new_ent;
					else ent_q <= left_ent;
				end
			end
			rps_pkg::CM_REPLACE: begin
				if (right_gt) ent_q <= right_ent;
				else if (gt) ent_q <= ctrl.new_ent;
			end
			rps_pkg::CM_ROTATE: ent_q <= right_ent;
			default: ent_q <= ent_q;
		endcase
	end

endmodule

[rtl/core/rps_recip_div.sv]
// ----------------------------------------------------------------------------
// rps_recip_div
// restoring divider for floor(2^32 / fitness), one quotient bit per cycle
// ----------------------------------------------------------------------------
module rps_recip_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rps_pkg::FIT_W-1:0]   divisor,
	output logic                        done,
	output logic [rps_pkg::RECIP_W-1:0] recip
);

	localparam int STEPS = rps_pkg::FIT_W + 1;
	localparam int SW    = $clog2(STEPS + 1);

	logic [rps_pkg::FIT_W-1:0] div_q;
	logic [rps_pkg::FIT_W-1:0] rem_q;
	logic [STEPS-1:0]          quo_q;
	logic [SW-1:0]             step_q;
	logic                      busy_q;
	logic                      done_q;
	logic [rps_pkg::FIT_W:0]   trial;
	logic                      fits;

	// dividend is a single one in its top bit
	assign trial = {rem_q, (step_q == '0)};
	assign fits  = trial >= {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + SW'(1);
				if (step_q == SW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rps_pkg::FIT_W'(trial - {1'b0, div_q})
			              : rps_pkg::FIT_W'(trial);
			quo_q <= {quo_q[STEPS-2:0], fits};
		end
	end

	assign done  = done_q;
	assign recip = (div_q < rps_pkg::FIT_W'(2)) ? '1 : quo_q[rps_pkg::RECIP_W-1:0];

endmodule

[rtl/core/roulette_population_select_top.sv]
// ----------------------------------------------------------------------------
// roulette_population_select_top
// ordered population chain with roulette pick by reciprocal fitness
// ----------------------------------------------------------------------------
// offer: runs the 33-step reciprocal divider, then inserts into the cell chain
// select: three rotations of the cell chain, one sum and two walks
// clear and other requests go straight to the finish state; one transaction at a time
// result sits in an output register, next transaction is taken meanwhile
// reset empties the table and clears control and config registers; entries and data registers hold no reset value
module roulette_population_select_top #(
	parameter int POP_SIZE = rps_pkg::POP_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rps_pkg::REQ_W-1:0]      req_type,
	input  logic [rps_pkg::FIT_W-1:0]      fitness,
	input  logic [rps_pkg::ID_W-1:0]       entry_id,
	input  logic [rps_pkg::FRAC_W-1:0]     first_fraction,
	input  logic [rps_pkg::FRAC_W-1:0]     second_fraction,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rps_pkg::ID_W-1:0]       first_parent_id,
	output logic [rps_pkg::ID_W-1:0]       second_parent_id,
	output logic                           accepted,
	output logic [rps_pkg::FIT_W-1:0]      best_fitness,
	output logic                           target_reached,
	output logic                           status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rps_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW    = $clog2(POP_SIZE + 1);
	localparam int IDXW  = $clog2(POP_SIZE);
	localparam int ACC_W = rps_pkg::RECIP_W + $clog2(POP_SIZE);
	localparam int HW    = ACC_W - 32;
	localparam int PW    = ACC_W + rps_pkg::FRAC_W;
	localparam int PHW   = rps_pkg::FRAC_W + HW;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DIV  = 9'b000000010,
		ST_INS  = 9'b000000100,
		ST_SUM  = 9'b000001000,
		ST_MUL1 = 9'b000010000,
		ST_MUL2 = 9'b000100000,
		ST_WALK = 9'b001000000,
		ST_WEND = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [CW-1:0]                 cnt_q;
	logic [rps_pkg::FIT_W-1:0]     tgt_fit_q;
	logic                          tgt_en_q;
	logic [rps_pkg::FIT_W-1:0]     f_q;
	logic [rps_pkg::ID_W-1:0]      id_q;
	logic [rps_pkg::FRAC_W-1:0]    u_q;
	logic [rps_pkg::FRAC_W-1:0]    u2_q;
	logic                          full_q;
	logic                          acc_q;
	logic                          stat_q;
	logic [ACC_W-1:0]              total_q;
	logic [ACC_W-1:0]              cum_q;
	logic [63:0]                   plo_q;
	logic [PW-1:0]                 prod_q;
	logic [IDXW-1:0]               t_q;
	logic                          pass_q;
	logic                          found_q;
	logic [IDXW-1:0]               pick_idx_q;
	logic [rps_pkg::ID_W-1:0]      pick_id_q;
	logic [rps_pkg::RECIP_W-1:0]   pick_w_q;
	logic [IDXW-1:0]               a_idx_q;
	logic [rps_pkg::ID_W-1:0]      pid1_q;
	logic [rps_pkg::ID_W-1:0]      pid2_q;

	logic                          out_valid_q;
	logic [rps_pkg::ID_W-1:0]      out_p1_q;
	logic [rps_pkg::ID_W-1:0]      out_p2_q;
	logic                          out_acc_q;
	logic [rps_pkg::FIT_W-1:0]     out_best_q;
	logic                          out_reach_q;
	logic                          out_stat_q;

	rps_pkg::cell_ctrl_t           ctrl;
	rps_pkg::entry_t               ent_w [POP_SIZE];
	logic                          gt_w  [POP_SIZE];
	logic                          div_start;
	logic                          div_done;
	logic [rps_pkg::RECIP_W-1:0]   div_recip;

	logic                          accept;
	logic                          full;
	logic                          offer_ok;
	rps_pkg::entry_t               head;
	logic                          in_tbl;
	logic                          cand;
	logic [ACC_W-1:0]              cum_n;
	logic                          hit;
	logic                          t_last;
	logic                          out_free;
	logic [rps_pkg::FIT_W-1:0]     best;
	logic [PHW-1:0]                phi;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign full      = (cnt_q == CW'(POP_SIZE));
	assign offer_ok  = !full || (fitness <= ent_w[0].fit);
	assign div_start = accept && (req_type == rps_pkg::REQ_OFFER) && offer_ok;

	// reciprocal unit
	rps_recip_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (fitness),
		.done    (div_done),
		.recip   (div_recip)
	);

	// chain control
	always_comb begin
		ctrl.new_ent.fit   = f_q;
		ctrl.new_ent.id    = id_q;
		ctrl.new_ent.recip = div_recip;
		if (state_q == ST_INS) ctrl.mode = full_q ? rps_pkg::CM_REPLACE : rps_pkg::CM_INSERT;
		else if (state_q == ST_SUM || state_q == ST_WALK) ctrl.mode = rps_pkg::CM_ROTATE;
		else ctrl.mode = rps_pkg::CM_HOLD;
	end

	// cell chain, head at slot zero, worst entry first
	for (genvar i = 0; i < POP_SIZE; i++) begin : g_cell
		rps_cell #(
			.POP_SIZE (POP_SIZE),
			.IDX      (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.cnt       (cnt_q),
			.left_ent  ((i == 0) ? ent_w[0] : ent_w[(i == 0) ? 0 : i - 1]),
			.left_gt   ((i == 0) ? 1'b1 : gt_w[(i == 0) ? 0 : i - 1]),
			.right_ent ((i == POP_SIZE - 1) ? ent_w[0] : ent_w[(i == POP_SIZE - 1) ? 0 : i + 1]),
			.right_gt  ((i == POP_SIZE - 1) ? 1'b0 : gt_w[(i == POP_SIZE - 1) ? 0 : i + 1]),
			.ent       (ent_w[i]),
			.gt        (gt_w[i])
		);
	end

	// head of the rotating chain during the sum and the walks
	assign head   = ent_w[0];
	assign in_tbl = (CW'(t_q) < cnt_q);
	assign cand   = in_tbl && !(pass_q && (t_q == a_idx_q));
	assign cum_n  = cum_q + ACC_W'(head.recip);
	assign hit    = ({cum_n, {rps_pkg::FRAC_W{1'b0}}} >= prod_q);
	assign t_last = (t_q == IDXW'(POP_SIZE - 1));

	// fraction times the upper bits of the total
	assign phi = PHW'(u_q) * PHW'(total_q[ACC_W-1:32]);

	// best entry is the last occupied slot
	assign best     = (cnt_q != '0) ? ent_w[IDXW'(cnt_q - CW'(1))].fit : '0;
	assign out_free = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_fit_q <= '0;
			tgt_en_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rps_pkg::CFG_TARGET_FITNESS: tgt_fit_q <= cfg_data;
				rps_pkg::CFG_TARGET_ENABLE:  tgt_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			t_q         <= '0;
			pass_q      <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						t_q    <= '0;
						pass_q <= 1'b0;
						case (req_type)
							rps_pkg::REQ_OFFER:  state_q <= offer_ok ? ST_DIV : ST_FIN;
							rps_pkg::REQ_SELECT: state_q <= (cnt_q < CW'(2)) ? ST_FIN : ST_SUM;
							rps_pkg::REQ_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_FIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_DIV: if (div_done) state_q <= ST_INS;
				ST_INS: begin
					if (!full_q) cnt_q <= cnt_q + CW'(1);
					state_q <= ST_FIN;
				end
				ST_SUM: begin
					t_q <= t_last ? '0 : t_q + IDXW'(1);
					if (t_last) state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: begin
					t_q     <= '0;
					found_q <= 1'b0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (cand && !found_q) found_q <= hit;
					t_q <= t_last ? '0 : t_q + IDXW'(1);
					if (t_last) state_q <= ST_WEND;
				end
				ST_WEND: begin
					pass_q  <= 1'b1;
					state_q <= pass_q ? ST_FIN : ST_MUL1;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				f_q     <= fitness;
				id_q    <= entry_id;
				u_q     <= first_fraction;
				u2_q    <= second_fraction;
				full_q  <= full;
				acc_q   <= (req_type == rps_pkg::REQ_OFFER) && offer_ok;
				stat_q  <= (req_type == rps_pkg::REQ_SELECT) && (cnt_q < CW'(2));
				pid1_q  <= '0;
				pid2_q  <= '0;
				total_q <= '0;
			end
			ST_SUM: if (in_tbl) total_q <= total_q + ACC_W'(head.recip);
			ST_MUL1: plo_q <= 64'(u_q) * 64'(total_q[31:0]);
			ST_MUL2: begin
				prod_q <= PW'(plo_q) + (PW'(phi) << 32);
				cum_q  <= '0;
			end
			ST_WALK: begin
				if (cand) cum_q <= cum_n;
				if (cand && !found_q) begin
					pick_idx_q <= t_q;
					pick_id_q  <= head.id;
					pick_w_q   <= head.recip;
				end
			end
			ST_WEND: begin
				if (!pass_q) begin
					a_idx_q <= pick_idx_q;
					pid1_q  <= pick_id_q;
					total_q <= total_q - ACC_W'(pick_w_q);
					u_q     <= u2_q;
				end else begin
					pid2_q <= pick_id_q;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_p1_q    <= pid1_q;
					out_p2_q    <= pid2_q;
					out_acc_q   <= acc_q;
					out_stat_q  <= stat_q;
					out_best_q  <= best;
					out_reach_q <= tgt_en_q && (cnt_q != '0) && (best <= tgt_fit_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign first_parent_id  = out_p1_q;
	assign second_parent_id = out_p2_q;
	assign accepted         = out_acc_q;
	assign best_fitness     = out_best_q;
	assign target_reached   = out_reach_q;
	assign status           = out_stat_q;

endmodule

[rtl/core/rps_checker.sv]
// ----------------------------------------------------------------------------
// rps_checker
// port-level checks of the roulette population select block
// ----------------------------------------------------------------------------
module rps_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [rps_pkg::ID_W-1:0]  first_parent_id,
	input logic [rps_pkg::ID_W-1:0]  second_parent_id,
	input logic                      accepted,
	input logic                      status
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one transaction at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// failed select carries no ids
	a_fail_ids: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> (first_parent_id == '0) && (second_parent_id == '0))
		else $error("ids on failed select");

	// an accepted offer is never a failed select
	a_acc_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> !status)
		else $error("accepted and status both set");

endmodule

bind roulette_population_select_top rps_checker u_rps_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.first_parent_id  (first_parent_id),
	.second_parent_id (second_parent_id),
	.accepted         (accepted),
	.status           (status)
);
